>>> hw/rtl/gdrs_pkg.sv
// Shared types, codes and silu table math for the gated recurrence scan.
`timescale 1ns / 1ps

package gdrs_pkg;

   localparam int MODEL_ROWS_DEF       = 64;
   localparam int STATE_COLUMNS_DEF    = 16;
   localparam int SILU_TABLE_DEPTH_DEF = 256;

   localparam int OP_W   = 2;
   localparam int ROW_W  = 6;
   localparam int COL_W  = 4;
   localparam int Q_W    = 16;
   localparam int VAL_W  = 32;
   localparam int CFG_W  = 5;
   localparam int ACC_W  = 40;

   localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OP_W-1:0] OP_STEP = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_STEP,
      KIND_READ
   } kind_type;

   // Classified item handed from front to back.
   typedef struct packed {
      kind_type                kind;
      logic                    in_range;
      logic                    last;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [Q_W-1:0]   decay;
      logic signed [Q_W-1:0]   drive;
      logic signed [Q_W-1:0]   readout;
      logic signed [Q_W-1:0]   gate;
      logic signed [Q_W-1:0]   load_value;
   } cmd_type;

   // Restoring unsigned divide, only used while building constant tables.
   function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^-(mag/4096) in Q31: series at mag/16, then squared four times.
   function automatic longint unsigned exp_neg_q31(longint unsigned mag);
      longint unsigned z;
      longint unsigned term;
      longint unsigned r;
      longint          sum;
      z    = mag << 15;
      term = 64'd1 << 31;
      sum  = longint'(term);
      for (int k = 1; k <= 12; k++) begin
         term = udiv64((term * z) >> 31, 64'(k));
         if (k[0]) sum = sum - longint'(term);
         else      sum = sum + longint'(term);
      end
      r = unsigned'(sum);
      for (int k = 0; k < 4; k++) begin
         r = (r * r + (64'd1 << 30)) >> 31;
      end
      return r;
   endfunction

   // silu(g/4096) in Q4.12, rounded half away from zero.
   function automatic logic signed [Q_W-1:0] silu_q12(int g);
      longint unsigned mag;
      longint unsigned e;
      longint unsigned den;
      longint unsigned s;
      longint unsigned p;
      logic signed [Q_W-1:0] ps;
      mag = (g < 0) ? longint'(-g) : longint'(g);
      e   = exp_neg_q31(mag);
      den = (64'd1 << 31) + e;
      if (g >= 0) s = udiv64((64'd1 << 62) + (den >> 1), den);
      else        s = udiv64((e << 31) + (den >> 1), den);
      p = (mag * s + (64'd1 << 30)) >> 31;
      if (p > 64'd32767) p = 64'd32767;
      ps = Q_W'(p);
      return (g < 0) ? -ps : ps;
   endfunction

endpackage

>>> hw/rtl/gdrs_front.sv
// Front end: classifies items and queues the ones with an effect.
`timescale 1ns / 1ps

module gdrs_front import gdrs_pkg::*; #(
   parameter int MODEL_ROWS    = MODEL_ROWS_DEF,
   parameter int STATE_COLUMNS = STATE_COLUMNS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CFG_W-1:0]      states_in_use,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_op,
   input  logic [ROW_W-1:0]      req_row,
   input  logic [COL_W-1:0]      req_column,
   input  logic signed [Q_W-1:0] req_decay,
   input  logic signed [Q_W-1:0] req_drive,
   input  logic signed [Q_W-1:0] req_readout,
   input  logic signed [Q_W-1:0] req_gate,
   input  logic signed [Q_W-1:0] req_load_value,
   output logic                  cmd_valid,
   output cmd_type               cmd,
   input  logic                  cmd_pop
);

   cmd_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   logic [8:0]  used;
   logic        in_range;
   logic        keep;
   logic        push;
   cmd_type     item;

   always_comb begin
      used = (states_in_use == '0) ? 9'd1 : 9'(states_in_use);
      if (32'(used) > 32'(STATE_COLUMNS)) used = 9'(STATE_COLUMNS);
      in_range = (32'(req_row) < 32'(MODEL_ROWS)) && (32'(req_column) < 32'(STATE_COLUMNS));

      item            = '0;
      item.in_range   = in_range;
      item.last       = (9'(req_column) == used - 9'd1);
      item.row        = req_row;
      item.col        = req_column;
      item.decay      = req_decay;
      item.drive      = req_drive;
      item.readout    = req_readout;
      item.gate       = req_gate;
      item.load_value = req_load_value;
      keep            = 1'b0;
      unique case (req_op)
         OP_LOAD: begin
            item.kind = KIND_LOAD;
            keep      = in_range;
         end
         OP_STEP: begin
            item.kind = KIND_STEP;
            keep      = in_range && (9'(req_column) < used);
         end
         OP_READ: begin
            item.kind = KIND_READ;
            keep      = 1'b1;
         end
         default: begin
            item.kind = KIND_LOAD;
            keep      = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && keep;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= item;
   end

endmodule

>>> hw/rtl/gdrs_back.sv
// Back end: state store, recurrence arithmetic, gate and result register.
`timescale 1ns / 1ps

module gdrs_back import gdrs_pkg::*; #(
   parameter int MODEL_ROWS       = MODEL_ROWS_DEF,
   parameter int STATE_COLUMNS    = STATE_COLUMNS_DEF,
   parameter int SILU_TABLE_DEPTH = SILU_TABLE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  cmd_type                 cmd,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic [ROW_W-1:0]        rsp_out_row,
   output logic                    rsp_is_readback
);

   localparam int DEPTH  = MODEL_ROWS * STATE_COLUMNS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SILU_W = $clog2(SILU_TABLE_DEPTH);

   typedef logic signed [Q_W-1:0] silu_arr_type [SILU_TABLE_DEPTH];

   function automatic silu_arr_type build_silu();
      silu_arr_type t;
      int           gu;
      for (int i = 0; i < SILU_TABLE_DEPTH; i++) begin
         gu   = int'(udiv64(64'(i * 65536 + SILU_TABLE_DEPTH - 1), 64'(SILU_TABLE_DEPTH)));
         t[i] = silu_q12(gu - 32768);
      end
      return t;
   endfunction

   localparam silu_arr_type SILU_TABLE = build_silu();

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL1, ST_UPD, ST_MUL2, ST_ACC, ST_MUL3, ST_RND, ST_EMIT
   } state_type;

   state_type               state_ff;
   cmd_type                 cur_ff;
   logic [ADDR_W-1:0]       cur_addr_ff;
   logic signed [Q_W-1:0]   store_mem [DEPTH];
   logic signed [Q_W-1:0]   rd_data_ff;
   logic signed [31:0]      prod1_ff;
   logic signed [Q_W-1:0]   h_ff;
   logic signed [31:0]      prod2_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [55:0]      prod3_ff;
   logic signed [VAL_W-1:0] res_ff;
   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic [ROW_W-1:0]        rsp_row_ff;
   logic                    rsp_rb_ff;

   logic [ADDR_W-1:0]       head_addr;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic signed [Q_W-1:0]   mem_wdata;
   logic signed [33:0]      upd_sum;
   logic signed [21:0]      upd_shift;
   logic signed [Q_W-1:0]   h_next;
   logic signed [ACC_W:0]   acc_sum;
   logic signed [ACC_W-1:0] acc_next;
   logic signed [56:0]      out_sum;
   logic signed [44:0]      out_shift;
   logic signed [VAL_W-1:0] y_next;
   logic [31:0]             idx_prod;
   logic [SILU_W-1:0]       silu_idx;
   logic                    out_free;

   assign head_addr = ADDR_W'(32'(cmd.row) * 32'(STATE_COLUMNS) + 32'(cmd.col));
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // h = floor((decay*h + drive*4096 + 2048) / 4096), saturated
      upd_sum   = 34'(prod1_ff) + 34'($signed({cur_ff.drive, 12'b0})) + 34'sd2048;
      upd_shift = 22'(upd_sum >>> 12);
      if (upd_shift > 22'sd32767)       h_next = 16'sh7fff;
      else if (upd_shift < -22'sd32768) h_next = 16'sh8000;
      else                              h_next = 16'(upd_shift);

      acc_sum = 41'(acc_ff) + 41'(prod2_ff);
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
         acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      else
         acc_next = acc_sum[ACC_W-1:0];

      out_sum   = 57'(prod3_ff) + 57'sd2048;
      out_shift = 45'(out_sum >>> 12);
      if (out_shift > 45'sd2147483647)       y_next = 32'sh7fffffff;
      else if (out_shift < -45'sd2147483648) y_next = 32'sh80000000;
      else                                   y_next = 32'(out_shift);

      idx_prod = 32'({cur_ff.gate[15] ^ 1'b1, cur_ff.gate[14:0]}) * 32'(SILU_TABLE_DEPTH);
      silu_idx = idx_prod[16 +: SILU_W];

      mem_we    = 1'b0;
      mem_waddr = cur_addr_ff;
      mem_wdata = h_next;
      if (cmd_pop && cmd.kind == KIND_LOAD) begin
         mem_we    = 1'b1;
         mem_waddr = head_addr;
         mem_wdata = cmd.load_value;
      end else if (state_ff == ST_UPD) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= store_mem[head_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cur_ff      <= cmd;
                  cur_addr_ff <= head_addr;
                  unique case (cmd.kind)
                     KIND_LOAD: state_ff <= ST_IDLE;
                     KIND_STEP: state_ff <= ST_MUL1;
                     KIND_READ: begin
                        if (cmd.in_range) begin
                           state_ff <= ST_MUL1;
                        end else begin
                           res_ff   <= '0;
                           state_ff <= ST_EMIT;
                        end
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_MUL1: begin
               if (cur_ff.kind == KIND_READ) begin
                  res_ff   <= 32'(rd_data_ff);
                  state_ff <= ST_EMIT;
               end else begin
                  prod1_ff <= 32'(cur_ff.decay) * 32'(rd_data_ff);
                  state_ff <= ST_UPD;
               end
            end
            ST_UPD: begin
               h_ff     <= h_next;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               prod2_ff <= 32'(h_ff) * 32'(cur_ff.readout);
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff   <= acc_next;
               state_ff <= cur_ff.last ? ST_MUL3 : ST_IDLE;
            end
            ST_MUL3: begin
               prod3_ff <= 56'(acc_ff) * 56'(SILU_TABLE[silu_idx]);
               acc_ff   <= '0;
               state_ff <= ST_RND;
            end
            ST_RND: begin
               res_ff   <= y_next;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_value_ff <= res_ff;
                  rsp_row_ff   <= cur_ff.row;
                  rsp_rb_ff    <= (cur_ff.kind == KIND_READ);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (state_ff == ST_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)                 rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_is_readback = rsp_rb_ff;

endmodule

>>> hw/rtl/gated_diagonal_recurrence_scan_top.sv
// Top level of the gated diagonal recurrence scan.
`timescale 1ns / 1ps
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------------
//  req     | in  | req_valid/req_stall  | op row column decay drive readout gate
//          |     |                      | load_value
//  rsp     | out | rsp_valid/rsp_stall  | value out_row is_readback
//  csr     | in  | csr_wr_en            | csr_wr_data (states in use)
//
//  Loads, reads and steps are all bound by the single back-end sequencer
//  (registered state read, then multiply, round, accumulate); a step on the
//  last column in use also applies the silu gate, rounds and emits a result.
//  A two-item queue lets the front keep accepting while the back works;
//  ignored items never enter it.
//  Reset (synchronous) clears queue, sequencer, accumulator and result valid;
//  the state store is not cleared and must be loaded before use.
//  rsp_stall holds the result register; the back waits until it drains.

module gated_diagonal_recurrence_scan_top import gdrs_pkg::*; #(
   parameter int MODEL_ROWS       = MODEL_ROWS_DEF,
   parameter int STATE_COLUMNS    = STATE_COLUMNS_DEF,
   parameter int SILU_TABLE_DEPTH = SILU_TABLE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CFG_W-1:0]        csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OP_W-1:0]         req_op,
   input  logic [ROW_W-1:0]        req_row,
   input  logic [COL_W-1:0]        req_column,
   input  logic signed [Q_W-1:0]   req_decay,
   input  logic signed [Q_W-1:0]   req_drive,
   input  logic signed [Q_W-1:0]   req_readout,
   input  logic signed [Q_W-1:0]   req_gate,
   input  logic signed [Q_W-1:0]   req_load_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic [ROW_W-1:0]        rsp_out_row,
   output logic                    rsp_is_readback
);

   // columns-in-use register, clamped downstream in the front end
   logic [CFG_W-1:0] states_in_use_ff;
   logic             cmd_valid;
   cmd_type          cmd;
   logic             cmd_pop;

   always_ff @(posedge clock) begin
      if (reset)          states_in_use_ff <= CFG_RESET;
      else if (csr_wr_en) states_in_use_ff <= csr_wr_data;
   end

   gdrs_front #(
      .MODEL_ROWS    (MODEL_ROWS),
      .STATE_COLUMNS (STATE_COLUMNS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .states_in_use  (states_in_use_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_row        (req_row),
      .req_column     (req_column),
      .req_decay      (req_decay),
      .req_drive      (req_drive),
      .req_readout    (req_readout),
      .req_gate       (req_gate),
      .req_load_value (req_load_value),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   gdrs_back #(
      .MODEL_ROWS       (MODEL_ROWS),
      .STATE_COLUMNS    (STATE_COLUMNS),
      .SILU_TABLE_DEPTH (SILU_TABLE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_out_row     (rsp_out_row),
      .rsp_is_readback (rsp_is_readback)
   );

`ifndef SYNTH
   // no result survives reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // readback carries a sign-extended 16-bit entry
   a_readback_sext: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_readback |->
         (rsp_value[31:15] == 17'h0 || rsp_value[31:15] == 17'h1ffff))
      else $error("readback value not sign-extended");

   // the back pops only what the queue holds
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("pop from empty queue");
`endif

endmodule
